// ===== sv/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
// No dependencies; used by gbs_ctrl, gbs_dpath and greedy_box_suppression.
`timescale 1ns / 1ps

package gbs_pkg;

    localparam int MAX_KEPT_DEF   = 64;
    localparam int COORD_W        = 16;
    localparam int SIZE_W         = 15;
    localparam int AREA_W         = 2 * SIZE_W;
    localparam int UNION_W        = AREA_W + 1;
    localparam int THR_W          = 16;
    localparam int SLOT_W         = 6;
    localparam int PROD_W         = THR_W + UNION_W;
    localparam logic [THR_W-1:0] THRESH_RESET = 16'd29491;

    typedef struct packed {
        logic [AREA_W-1:0]         area;
        logic [SIZE_W-1:0]         height;
        logic [SIZE_W-1:0]         width;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic issue;
        logic finish;
        logic store;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic keep;
    } stat_t;

endpackage

// ===== sv/gbs_ctrl.sv =====
// Controller for greedy box suppression: handshakes, scan sequencing, kept count.
// Depends on gbs_pkg for the command and status structs.
`timescale 1ns / 1ps

module gbs_ctrl #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF,
    parameter int AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
    parameter int CW       = $clog2(MAX_KEPT + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    input  logic           s_first,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  gbs_pkg::stat_t stat,
    output gbs_pkg::cmd_t  cmd,
    output logic [AW-1:0]  scan_addr,
    output logic [CW-1:0]  kept_count
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          mvalid_reg, mvalid_next;
    logic          out_free;
    logic          store;

    assign out_free = !mvalid_reg || m_tready;
    assign store    = stat.keep && (count_reg < CW'(MAX_KEPT));

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (m_tready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_first) begin
                        count_next = '0;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.load = 1'b1;
                idx_next = '0;
                state_next = (count_reg == '0) ? ST_DRAIN : ST_SCAN;
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                idx_next  = CW'(idx_reg + 1'b1);
                if (CW'(idx_reg + 1'b1) == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.finish  = 1'b1;
                    cmd.store   = store;
                    mvalid_next = 1'b1;
                    if (store) begin
                        count_next = CW'(count_reg + 1'b1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            mvalid_reg <= mvalid_next;
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = mvalid_reg;
    assign scan_addr  = idx_reg[AW-1:0];
    assign kept_count = count_reg;

endmodule

// ===== sv/gbs_dpath.sv =====
// Datapath for greedy box suppression: kept-box memory, pipelined IoU test,
// threshold register and result registers. Depends on gbs_pkg.
`timescale 1ns / 1ps

module gbs_dpath #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF,
    parameter int AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
    parameter int CW       = $clog2(MAX_KEPT + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  gbs_pkg::cmd_t                      cmd,
    input  logic [AW-1:0]                      scan_addr,
    input  logic [CW-1:0]                      kept_count,
    input  logic signed [gbs_pkg::COORD_W-1:0] box_left,
    input  logic signed [gbs_pkg::COORD_W-1:0] box_top,
    input  logic [gbs_pkg::SIZE_W-1:0]         box_width,
    input  logic [gbs_pkg::SIZE_W-1:0]         box_height,
    input  logic                               cfg_wr_en,
    input  logic [gbs_pkg::THR_W-1:0]          cfg_wr_data,
    output gbs_pkg::stat_t                     stat,
    output logic                               out_keep,
    output logic [gbs_pkg::SLOT_W-1:0]         out_slot,
    output logic                               out_full
);

    function automatic logic [gbs_pkg::SIZE_W-1:0] overlap_len(
        input logic signed [gbs_pkg::COORD_W-1:0] a0,
        input logic [gbs_pkg::SIZE_W-1:0]         al,
        input logic signed [gbs_pkg::COORD_W-1:0] b0,
        input logic [gbs_pkg::SIZE_W-1:0]         bl
    );
        logic signed [gbs_pkg::COORD_W:0] as, bs, ae, be, lo, hi;
        as = (gbs_pkg::COORD_W + 1)'(a0);
        bs = (gbs_pkg::COORD_W + 1)'(b0);
        ae = as + $signed({2'b00, al});
        be = bs + $signed({2'b00, bl});
        lo = (as > bs) ? as : bs;
        hi = (ae < be) ? ae : be;
        overlap_len = (hi > lo) ? gbs_pkg::SIZE_W'(hi - lo) : '0;
    endfunction

    gbs_pkg::entry_t kept_mem [MAX_KEPT];

    logic [gbs_pkg::THR_W-1:0]          thr_reg;
    gbs_pkg::entry_t                    box_reg;
    logic                               suppress_reg;
    gbs_pkg::entry_t                    rd_reg;
    logic                               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [gbs_pkg::SIZE_W-1:0]         ox_reg, oy_reg;
    logic [gbs_pkg::AREA_W-1:0]         karea2_reg, karea3_reg;
    logic [gbs_pkg::AREA_W-1:0]         inter3_reg, inter4_reg;
    logic [gbs_pkg::UNION_W-1:0]        uni4_reg;
    logic [gbs_pkg::PROD_W-1:0]         prod5_reg;
    logic [gbs_pkg::AREA_W+15:0]        inter5_reg;
    logic                               nz5_reg;
    logic [CW+gbs_pkg::SLOT_W-1:0]      count_wide;

    assign count_wide = {{gbs_pkg::SLOT_W{1'b0}}, kept_count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= gbs_pkg::THRESH_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            box_reg.left   <= box_left;
            box_reg.top    <= box_top;
            box_reg.width  <= box_width;
            box_reg.height <= box_height;
        end
        if (cmd.load) begin
            box_reg.area <= gbs_pkg::AREA_W'(box_reg.width) * gbs_pkg::AREA_W'(box_reg.height);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            rd_reg <= kept_mem[scan_addr];
        end
        if (cmd.store) begin
            kept_mem[kept_count[AW-1:0]] <= box_reg;
        end
    end

    // compare pipeline: overlap, intersection, union, scaled union, test
    always_ff @(posedge aclk) begin
        ox_reg     <= overlap_len(box_reg.left, box_reg.width, rd_reg.left, rd_reg.width);
        oy_reg     <= overlap_len(box_reg.top, box_reg.height, rd_reg.top, rd_reg.height);
        karea2_reg <= rd_reg.area;
        inter3_reg <= gbs_pkg::AREA_W'(ox_reg) * gbs_pkg::AREA_W'(oy_reg);
        karea3_reg <= karea2_reg;
        uni4_reg   <= gbs_pkg::UNION_W'(box_reg.area) + gbs_pkg::UNION_W'(karea3_reg)
                      - gbs_pkg::UNION_W'(inter3_reg);
        inter4_reg <= inter3_reg;
        prod5_reg  <= gbs_pkg::PROD_W'(thr_reg) * gbs_pkg::PROD_W'(uni4_reg);
        inter5_reg <= {inter4_reg, 16'h0000};
        nz5_reg    <= (uni4_reg != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            suppress_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            if (cmd.capture) begin
                suppress_reg <= 1'b0;
            end else if (v5_reg && nz5_reg
                         && (gbs_pkg::PROD_W'(inter5_reg) > prod5_reg)) begin
                suppress_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_keep <= !suppress_reg;
            out_full <= !suppress_reg && !cmd.store;
            out_slot <= cmd.store ? count_wide[gbs_pkg::SLOT_W-1:0] : '0;
        end
    end

    assign stat.busy = v1_reg | v2_reg | v3_reg | v4_reg | v5_reg;
    assign stat.keep = !suppress_reg;

endmodule

// ===== sv/greedy_box_suppression.sv =====
// Top level of greedy box suppression: stream ports, controller and datapath.
// Depends on gbs_pkg, gbs_ctrl and gbs_dpath.
//
//   channel  dir  group                      beat carries
//   s_       in   tvalid tready tdata tuser  one box, tuser = first of set
//   m_       out  tvalid tready tdata tuser  keep decision, tuser = store full
//   cfg_     in   wr_en wr_data              overlap threshold, Q0.16
//
// The pipelined IoU unit compares one kept box per cycle out of the kept memory;
// with an empty kept list no comparison is issued.
// Reset clears the kept count and the handshake state and sets the threshold to 29491.
// A result waiting on m_tready holds the next box in its final cycle; a new
// box is taken while that result waits.
`timescale 1ns / 1ps

module greedy_box_suppression #(
    parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // box_left, box_top, box_width, box_height, pad
    input  logic        s_tuser,   // first_of_set
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // keep, kept_slot, pad
    output logic        m_tuser,   // list_full
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);

    gbs_pkg::cmd_t                 cmd;
    gbs_pkg::stat_t                stat;
    logic [AW-1:0]                 scan_addr;
    logic [CW-1:0]                 kept_count;
    logic                          out_keep;
    logic                          out_full;
    logic [gbs_pkg::SLOT_W-1:0]    out_slot;

    gbs_ctrl #(
        .MAX_KEPT (MAX_KEPT),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_first    (s_tuser),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .stat       (stat),
        .cmd        (cmd),
        .scan_addr  (scan_addr),
        .kept_count (kept_count)
    );

    gbs_dpath #(
        .MAX_KEPT (MAX_KEPT),
        .AW       (AW),
        .CW       (CW)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .scan_addr   (scan_addr),
        .kept_count  (kept_count),
        .box_left    ($signed(s_tdata[15:0])),
        .box_top     ($signed(s_tdata[31:16])),
        .box_width   (s_tdata[46:32]),
        .box_height  (s_tdata[61:47]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat),
        .out_keep    (out_keep),
        .out_slot    (out_slot),
        .out_full    (out_full)
    );

    assign m_tdata = {1'b0, out_slot, out_keep};
    assign m_tuser = out_full;

    a_full_implies_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[0])
        else $error("list_full set on a suppressed box");

    a_drop_has_no_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[6:1] == '0))
        else $error("suppressed box carries a slot");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_count <= CW'(MAX_KEPT))
        else $error("kept count past store depth");

    a_issue_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (CW'(scan_addr) < kept_count))
        else $error("scan read beyond kept count");

endmodule
